@@ rtl/wmm_pkg.sv @@
// wmm_pkg: shared types and constants of the wide modular multiplier
`default_nettype none

package wmm_pkg;

	// operand word and field widths
	localparam int unsigned WORD_W = 64;
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned CMD_W  = 2;

	// request commands
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_X   = 2'd0,
		CMD_LOAD_Y   = 2'd1,
		CMD_LOAD_M   = 2'd2,
		CMD_COMPUTE  = 2'd3
	} cmd_t;

	// status from the arithmetic core to the top level
	typedef struct packed {
		logic done;
		logic mzero;
	} wmm_status_t;

endpackage

`default_nettype wire

@@ rtl/wmm_req_if.sv @@
// wmm_req_if: request channel carrying operand loads and compute commands
`default_nettype none

interface wmm_req_if;
	import wmm_pkg::*;

	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [IDX_W-1:0]  word_index;
	logic [WORD_W-1:0] word_value;

	modport source (output valid, cmd, word_index, word_value, input ready);
	modport sink (input valid, cmd, word_index, word_value, output ready);
endinterface

`default_nettype wire

@@ rtl/wmm_rsp_if.sv @@
// wmm_rsp_if: result channel carrying the residue words of each compute request
`default_nettype none

interface wmm_rsp_if;
	import wmm_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] result_word;
	logic [IDX_W-1:0]  result_index;
	logic              last;
	logic              modulus_zero;

	modport source (output valid, result_word, result_index, last, modulus_zero,
		input ready);
	modport sink (input valid, result_word, result_index, last, modulus_zero,
		output ready);
endinterface

`default_nettype wire

@@ rtl/wide_modular_multiplier.sv @@
// wide_modular_multiplier: operand stores, request decode and result word output
`default_nettype none

// Computes (x*y) mod m on unsigned integers of WORDS 64-bit words. A load request
// writes one word of x, y or m; loads beyond the operand are ignored. A compute
// request runs on one shared (N+1)-bit adder/subtractor, with N = 64*WORDS: it
// first reduces y modulo m bit by bit, then each bit of x, most significant first,
// gets a modular double, followed when the bit is set by an add and a conditional
// subtract. The result then leaves as WORDS words, least significant first, one per
// accepted beat, with last on the top word. A zero modulus skips the arithmetic and
// returns zero words flagged by modulus_zero. The block takes no request while a
// compute or its output is open.
module wide_modular_multiplier #(
	parameter int unsigned WORDS = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wmm_req_if.sink    req,
	wmm_rsp_if.source  rsp
);
	import wmm_pkg::*;

	localparam int unsigned N     = WORDS * WORD_W;
	localparam int unsigned OIX_W = $clog2(WORDS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [WORD_W-1:0] x_q [WORDS];
	logic [WORD_W-1:0] y_q [WORDS];
	logic [WORD_W-1:0] m_q [WORDS];
	logic [N-1:0]      out_sh_q;
	logic [OIX_W-1:0]  idx_q;
	logic              mz_q;

	logic         req_fire;
	logic         rsp_fire;
	logic         start;
	logic [N-1:0] x_flat;
	logic [N-1:0] y_flat;
	logic [N-1:0] m_flat;
	logic [N-1:0] core_result;
	wmm_status_t  core_status;

	// handshakes
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_fire  = rsp.valid && rsp.ready;
	assign start     = req_fire && (cmd_t'(req.cmd) == CMD_COMPUTE);

	// operand stores, one register per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WORDS; k++) begin
				x_q[k] <= '0;
				y_q[k] <= '0;
				m_q[k] <= '0;
			end
		end else if (req_fire) begin
			for (int k = 0; k < WORDS; k++) begin
				if (32'(req.word_index) == k) begin
					case (cmd_t'(req.cmd))
						CMD_LOAD_X: x_q[k] <= req.word_value;
						CMD_LOAD_Y: y_q[k] <= req.word_value;
						CMD_LOAD_M: m_q[k] <= req.word_value;
						default: begin
						end
					endcase
				end
			end
		end
	end

	// flatten stores into wide operands
	always_comb begin
		for (int k = 0; k < WORDS; k++) begin
			x_flat[k*WORD_W +: WORD_W] = x_q[k];
			y_flat[k*WORD_W +: WORD_W] = y_q[k];
			m_flat[k*WORD_W +: WORD_W] = m_q[k];
		end
	end

	wmm_core #(.WORDS(WORDS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.x      (x_flat),
		.y      (y_flat),
		.m      (m_flat),
		.status (core_status),
		.result (core_result)
	);

	// request/compute/output control and result word shifter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			out_sh_q <= '0;
			idx_q    <= '0;
			mz_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (core_status.done) begin
						out_sh_q <= core_result;
						mz_q     <= core_status.mzero;
						idx_q    <= '0;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (rsp_fire) begin
						out_sh_q <= out_sh_q >> WORD_W;
						if (32'(idx_q) == WORDS - 1) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result beat
	assign rsp.valid        = (state_q == ST_EMIT);
	assign rsp.result_word  = out_sh_q[WORD_W-1:0];
	assign rsp.result_index = IDX_W'(idx_q);
	assign rsp.last         = (32'(idx_q) == WORDS - 1);
	assign rsp.modulus_zero = mz_q;
endmodule

`default_nettype wire

@@ rtl/wmm_addsub.sv @@
// wmm_addsub: shared wide adder/subtractor used by every step of the core
`default_nettype none

module wmm_addsub #(
	parameter int unsigned W = 257
) (
	input  wire logic [W-1:0] a,
	input  wire logic [W-1:0] b,
	input  wire logic         sub,
	output logic [W-1:0]      sum,
	output logic              cout
);
	logic [W:0] full;

	// a + b, or a - b as a + ~b + 1; carry out set means no borrow
	always_comb begin
		full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
		sum  = full[W-1:0];
		cout = full[W];
	end
endmodule

`default_nettype wire

@@ rtl/wmm_core.sv @@
// wmm_core: bit-serial sequencer computing (x*y) mod m on the shared adder
`default_nettype none

module wmm_core #(
	parameter int unsigned WORDS = 4
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	input  wire logic [WORDS*wmm_pkg::WORD_W-1:0]      x,
	input  wire logic [WORDS*wmm_pkg::WORD_W-1:0]      y,
	input  wire logic [WORDS*wmm_pkg::WORD_W-1:0]      m,
	output wmm_pkg::wmm_status_t                       status,
	output logic [WORDS*wmm_pkg::WORD_W-1:0]           result
);
	import wmm_pkg::*;

	localparam int unsigned N     = WORDS * WORD_W;
	localparam int unsigned CNT_W = $clog2(N);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDY,
		ST_DBL,
		ST_ADD,
		ST_SUB,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [N:0]       r_q;
	logic [N-1:0]     yr_q;
	logic [N-1:0]     x_sh_q;
	logic [N-1:0]     y_sh_q;
	logic [CNT_W-1:0] cnt_q;
	logic             mz_q;

	logic [N:0] au_a;
	logic [N:0] au_b;
	logic       au_sub;
	logic [N:0] au_sum;
	logic       au_cout;
	logic [N:0] red;

	wmm_addsub #(.W(N + 1)) u_addsub (
		.a    (au_a),
		.b    (au_b),
		.sub  (au_sub),
		.sum  (au_sum),
		.cout (au_cout)
	);

	// operand select for the shared unit
	always_comb begin
		au_a   = r_q;
		au_b   = {1'b0, m};
		au_sub = 1'b1;
		case (state_q)
			ST_REDY: begin
				au_a = {r_q[N-1:0], y_sh_q[N-1]};
			end
			ST_DBL: begin
				au_a = {r_q[N-1:0], 1'b0};
			end
			ST_ADD: begin
				au_b   = {1'b0, yr_q};
				au_sub = 1'b0;
			end
			default: begin
				au_a = r_q;
			end
		endcase
		// conditional subtract: keep the difference when it did not borrow
		red = au_cout ? au_sum : au_a;
	end

	// sequencer: reduce y mod m, then left-to-right double and add over x
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			yr_q    <= '0;
			x_sh_q  <= '0;
			y_sh_q  <= '0;
			cnt_q   <= '0;
			mz_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						r_q    <= '0;
						x_sh_q <= x;
						y_sh_q <= y;
						cnt_q  <= CNT_W'(N - 1);
						if (m == '0) begin
							mz_q    <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							mz_q    <= 1'b0;
							state_q <= ST_REDY;
						end
					end
				end
				ST_REDY: begin
					y_sh_q <= y_sh_q << 1;
					if (cnt_q == '0) begin
						yr_q    <= red[N-1:0];
						r_q     <= '0;
						cnt_q   <= CNT_W'(N - 1);
						state_q <= ST_DBL;
					end else begin
						r_q   <= red;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DBL: begin
					r_q <= red;
					if (x_sh_q[N-1]) begin
						state_q <= ST_ADD;
					end else if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						x_sh_q <= x_sh_q << 1;
						cnt_q  <= cnt_q - 1'b1;
					end
				end
				ST_ADD: begin
					r_q     <= au_sum;
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					r_q <= red;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						x_sh_q  <= x_sh_q << 1;
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_DBL;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// status and residue out
	always_comb begin
		status.done  = (state_q == ST_DONE);
		status.mzero = mz_q;
		result       = r_q[N-1:0];
	end
endmodule

`default_nettype wire

@@ sim/wide_modular_multiplier_tb.sv @@
// wide_modular_multiplier_tb: self-checking testbench for the wide modular multiplier
`timescale 1ns / 100ps

module wide_modular_multiplier_tb;
	import wmm_pkg::*;

	localparam int unsigned WORDS        = 4;
	localparam int unsigned OPER_W       = WORDS * WORD_W;
	localparam int unsigned RANDOM_ITEMS = 480;
	localparam int unsigned TAIL_ITEMS   = 60;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned REPORT_MAX   = 10;
	localparam int unsigned SMALL_MAX    = 'h0F;

	typedef struct packed {
		cmd_t              cmd;
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] val;
	} wmm_req_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [IDX_W-1:0]  index;
		logic              last;
		logic              mzero;
	} residue_beat_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// driver and monitor state, known from time zero
	logic     drv_valid   = 1'b0;
	wmm_req_t drv_req     = '0;
	logic     mon_ready   = 1'b0;
	logic     tail_phase  = 1'b0;
	int       send_gap    = 0;
	int       recv_stall  = 0;
	int       issued      = 0;
	int       accepted    = 0;
	int       fail_count  = 0;

	wmm_req_t      pending[$];
	residue_beat_t residues_due[$];
	residue_beat_t got_beat;
	residue_beat_t want_beat;

	// predicted operand stores
	logic [OPER_W-1:0] x_val = '0;
	logic [OPER_W-1:0] y_val = '0;
	logic [OPER_W-1:0] m_val = '0;

	wmm_req_if req_ch ();
	wmm_rsp_if rsp_ch ();

	assign req_ch.valid      = drv_valid;
	assign req_ch.cmd        = drv_req.cmd;
	assign req_ch.word_index = drv_req.idx;
	assign req_ch.word_value = drv_req.val;
	assign rsp_ch.ready      = mon_ready;

	wide_modular_multiplier #(
		.WORDS(WORDS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// reset asserted from time zero, released away from the rising edge
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// update stores on a load, predict residue words on a compute
	function automatic void model_request(input wmm_req_t r);
		logic [2*OPER_W-1:0] product;
		logic [2*OPER_W-1:0] residue;
		logic                mzero;
		residue_beat_t       beat;
		if (r.cmd != CMD_COMPUTE) begin
			if (r.idx < WORDS) begin
				case (r.cmd)
					CMD_LOAD_X: x_val[r.idx*WORD_W +: WORD_W] = r.val;
					CMD_LOAD_Y: y_val[r.idx*WORD_W +: WORD_W] = r.val;
					default:    m_val[r.idx*WORD_W +: WORD_W] = r.val;
				endcase
			end
			return;
		end
		mzero = (m_val == '0);
		residue = '0;
		if (!mzero) begin
			product = {{OPER_W{1'b0}}, x_val} * {{OPER_W{1'b0}}, y_val};
			residue = product % {{OPER_W{1'b0}}, m_val};
		end
		for (int k = 0; k < WORDS; k++) begin
			beat.word  = mzero ? '0 : residue[k*WORD_W +: WORD_W];
			beat.index = IDX_W'(k);
			beat.last  = (k == WORDS - 1);
			beat.mzero = mzero;
			residues_due.push_back(beat);
		end
	endfunction

	task automatic flag_mismatch(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic push_req(input cmd_t c, input logic [IDX_W-1:0] i,
			input logic [WORD_W-1:0] v);
		wmm_req_t r;
		r.cmd = c;
		r.idx = i;
		r.val = v;
		pending.push_back(r);
		issued++;
	endtask

	// operand word with a bias toward edge values
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return WORD_W'($urandom_range(0, SMALL_MAX));
			3: return {{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, WORD_W - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// random subset of the words of one operand
	task automatic load_operand(input cmd_t c);
		for (int w = 0; w < WORDS; w++) begin
			if ($urandom_range(0, 2) != 0)
				push_req(c, IDX_W'(w), pick_word());
		end
	endtask

	// request driver with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			send_gap  <= 0;
		end else begin
			if (drv_valid && req_ch.ready) begin
				model_request(drv_req);
				accepted <= accepted + 1;
			end
			tail_phase <= (pending.size() < TAIL_ITEMS);
			if (!drv_valid || req_ch.ready) begin
				if (send_gap > 0) begin
					send_gap  <= send_gap - 1;
					drv_valid <= 1'b0;
				end else if (pending.size() != 0 && !tail_phase &&
						$urandom_range(0, 5) == 0) begin
					send_gap  <= $urandom_range(0, 6);
					drv_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					drv_req   <= pending.pop_front();
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mon_ready  <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (rsp_ch.valid && mon_ready) begin
				got_beat.word  = rsp_ch.result_word;
				got_beat.index = rsp_ch.result_index;
				got_beat.last  = rsp_ch.last;
				got_beat.mzero = rsp_ch.modulus_zero;
				if (residues_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result word %h idx %0d last %b mzero %b",
						got_beat.word, got_beat.index, got_beat.last, got_beat.mzero));
				end else begin
					want_beat = residues_due.pop_front();
					if (got_beat !== want_beat)
						flag_mismatch($sformatf(
							"result mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
							want_beat.word, want_beat.index, want_beat.last,
							want_beat.mzero, got_beat.word, got_beat.index,
							got_beat.last, got_beat.mzero));
				end
			end
			if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				mon_ready  <= 1'b0;
			end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
				recv_stall <= $urandom_range(0, 6);
				mon_ready  <= 1'b0;
			end else begin
				mon_ready <= 1'b1;
			end
		end
	end

	// stimulus and end of run
	initial begin
		// zero modulus straight after reset
		push_req(CMD_COMPUTE, 2'd0, '0);
		// largest operands, still no modulus
		for (int w = 0; w < WORDS; w++) push_req(CMD_LOAD_X, IDX_W'(w), '1);
		for (int w = 0; w < WORDS; w++) push_req(CMD_LOAD_Y, IDX_W'(w), '1);
		push_req(CMD_COMPUTE, 2'd3, '1);
		// largest modulus, word value in compute ignored
		for (int w = 0; w < WORDS; w++) push_req(CMD_LOAD_M, IDX_W'(w), '1);
		push_req(CMD_COMPUTE, 2'd1, '1);
		// odd low word, then modulus of one
		push_req(CMD_LOAD_M, 2'd0, 64'd1);
		push_req(CMD_COMPUTE, 2'd2, {$urandom, $urandom});
		for (int w = 1; w < WORDS; w++) push_req(CMD_LOAD_M, IDX_W'(w), '0);
		push_req(CMD_COMPUTE, 2'd0, '0);
		// single-word modulus, then a short x
		push_req(CMD_LOAD_M, 2'd0, '1);
		push_req(CMD_COMPUTE, 2'd0, '0);
		push_req(CMD_LOAD_X, 2'd3, '0);
		push_req(CMD_COMPUTE, 2'd3, '0);

		// random part: mostly load sequences closed by a compute, some noise
		while (issued < 25 + RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 8) begin
				load_operand(CMD_LOAD_X);
				load_operand(CMD_LOAD_Y);
				load_operand(CMD_LOAD_M);
				push_req(CMD_COMPUTE, IDX_W'($urandom_range(0, 3)), {$urandom, $urandom});
			end else begin
				push_req(cmd_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
					pick_word());
			end
		end

		// wait for all requests, then all results, then a short drain
		do @(posedge clk); while (accepted != issued);
		while (residues_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (residues_due.size() != 0)
			flag_mismatch($sformatf("%0d result words never arrived", residues_due.size()));
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
